// ===== sv/lupp_pkg.sv =====
// ---------------------------------------------------------------------------
// lupp_pkg
// shared constants and sequencer states for the lu decomposition block
// ---------------------------------------------------------------------------
package lupp_pkg;

   localparam int DIM_DEFAULT = 4;
   localparam int DATA_W      = 32;
   localparam int PIVOT_W     = 3;
   localparam int FRAC_W      = 16;
   localparam int DIV_W       = DATA_W + FRAC_W;
   localparam int DIV_CNT_W   = $clog2(DIV_W);

   typedef enum logic [23:0] {
      S_LOAD    = 24'h000001,
      S_SC_RD   = 24'h000002,
      S_SC_ACC  = 24'h000004,
      S_PV_RD   = 24'h000008,
      S_PV_CHK  = 24'h000010,
      S_PV_M1   = 24'h000020,
      S_PV_M2   = 24'h000040,
      S_SW_RDA  = 24'h000080,
      S_SW_RDB  = 24'h000100,
      S_SW_WRB  = 24'h000200,
      S_SW_WRK  = 24'h000400,
      S_SS_A    = 24'h000800,
      S_SS_B    = 24'h001000,
      S_PP_RD   = 24'h002000,
      S_PP_CHK  = 24'h004000,
      S_EL_RD   = 24'h008000,
      S_EL_INI  = 24'h010000,
      S_EL_DIV  = 24'h020000,
      S_EL_WR   = 24'h040000,
      S_RD_KJ   = 24'h080000,
      S_MUL     = 24'h100000,
      S_SUB     = 24'h200000,
      S_OUT_RD  = 24'h400000,
      S_OUT_SH  = 24'h800000
   } state_type;

endpackage

// ===== sv/lu_decompose_partial_pivot.sv =====
// ---------------------------------------------------------------------------
// lu_decompose_partial_pivot
// in-place lu decomposition with scaled partial pivoting on one shared
// multiplier and one radix-2 divider under a sequencer
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_element_value
//  rsp     | out       | rsp_valid/rsp_stall | rsp_lu_value, rsp_pivot_row,
//          |           |                     | rsp_parity_negative, rsp_singular,
//          |           |                     | rsp_last_result
//
// one element is taken per cycle while loading; req_stall is high from the
// last element until the final result transaction. the work runs the row
// scales, then per column a pivot search over the rows from the diagonal down,
// a row swap when the pivot row differs, the pivot check, a 48-step division
// per lower row and a multiply-subtract per reduced element, then one result at
// a time. reset clears the sequencer, pivots and flags. a stalled result simply holds the sequencer.
module lu_decompose_partial_pivot #(
   parameter int DIM = lupp_pkg::DIM_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [lupp_pkg::DATA_W-1:0]  req_element_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [lupp_pkg::DATA_W-1:0]  rsp_lu_value,
   output logic [lupp_pkg::PIVOT_W-1:0]        rsp_pivot_row,
   output logic                                rsp_parity_negative,
   output logic                                rsp_singular,
   output logic                                rsp_last_result
);

   localparam int IW = $clog2(DIM);
   localparam int AW = $clog2(DIM * DIM);
   localparam int DW = lupp_pkg::DATA_W;
   localparam int QW = lupp_pkg::DIV_W;
   localparam int CW = lupp_pkg::DIV_CNT_W;
   localparam logic [IW-1:0] LAST = IW'(DIM - 1);
   localparam logic [AW-1:0] CNT_LAST = AW'(DIM * DIM - 1);
   localparam logic [CW-1:0] DIV_LAST = CW'(QW - 1);

   function automatic logic [AW-1:0] idx(input logic [IW-1:0] row, input logic [IW-1:0] col);
      idx = AW'(int'(row) * DIM + int'(col));
   endfunction

   function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
      mag = v[DW-1] ? (~v + DW'(1)) : v;
   endfunction

   lupp_pkg::state_type state_ff, state_in;

   logic signed [DW-1:0] mem [DIM*DIM];
   logic signed [DW-1:0] mem_q_ff;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr, mem_raddr;
   logic signed [DW-1:0] mem_wdata;

   logic [AW-1:0] load_cnt_ff, load_cnt_in;
   logic [IW-1:0] r_ff, r_in, c_ff, c_in, k_ff, k_in, i_ff, i_in, j_ff, j_in;
   logic [IW-1:0] best_ff, best_in, orow_ff, orow_in, ocol_ff, ocol_in;
   logic [IW-1:0] pidx_ff [DIM];
   logic [IW-1:0] pidx_in [DIM];
   logic [DW-1:0] rs_ff [DIM];
   logic [DW-1:0] rs_in [DIM];
   logic [DW-1:0] big_ff, big_in, m_ff, m_in, bm_ff, bm_in, bs_ff, bs_in;
   logic [DW-1:0] t_ff, t_in, dvs_ff, dvs_in;
   logic          found_ff, found_in, parity_ff, parity_in, sing_ff, sing_in;
   logic signed [DW-1:0] piv_ff, piv_in, l_ff, l_in;
   logic [63:0]   prod_ff, prod_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [QW-1:0] dq_ff, dq_in;
   logic [CW-1:0] dcnt_ff, dcnt_in;
   logic          dneg_ff, dneg_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0] rsp_lu_ff, rsp_lu_in;
   logic [lupp_pkg::PIVOT_W-1:0] rsp_piv_ff, rsp_piv_in;
   logic rsp_par_ff, rsp_par_in, rsp_sing_ff, rsp_sing_in, rsp_last_ff, rsp_last_in;

   // shared multiplier
   logic signed [DW:0]       mul_a, mul_b;
   logic signed [2*DW+1:0]   mul_p;
   assign mul_p = mul_a * mul_b;

   logic [DW-1:0]        m_val, big_val;
   logic                 pv_adv, take;
   logic [DW:0]          rem_sh;
   logic                 div_ge;
   logic signed [DW-1:0] l_val;
   logic signed [63:0]   pr;
   logic signed [QW-1:0] p_val;
   logic signed [QW:0]   diff;
   logic signed [DW-1:0] sub_val;

   always_comb begin
      m_val  = mag(mem_q_ff);
      rem_sh = {rem_ff[DW-1:0], dq_ff[QW-1]};
      div_ge = rem_sh >= {1'b0, dvs_ff};
      if (dneg_ff) begin
         l_val = (dq_ff > QW'(64'h8000_0000)) ? 32'sh8000_0000 : $signed(~dq_ff[DW-1:0] + DW'(1));
      end else begin
         l_val = (dq_ff > QW'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(dq_ff[DW-1:0]);
      end
      // truncate toward zero on the fixed point rescale
      pr    = $signed(prod_ff) + (prod_ff[63] ? 64'sd65535 : 64'sd0);
      p_val = pr[63:16];
      diff  = {{(QW-DW+1){mem_q_ff[DW-1]}}, mem_q_ff} - {p_val[QW-1], p_val};
      if (!diff[QW] && (|diff[QW-1:DW-1])) begin
         sub_val = 32'sh7FFF_FFFF;
      end else if (diff[QW] && !(&diff[QW-1:DW-1])) begin
         sub_val = 32'sh8000_0000;
      end else begin
         sub_val = diff[DW-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      load_cnt_in  = load_cnt_ff;
      r_in = r_ff;  c_in = c_ff;  k_in = k_ff;  i_in = i_ff;  j_in = j_ff;
      best_in = best_ff;  orow_in = orow_ff;  ocol_in = ocol_ff;
      pidx_in = pidx_ff;  rs_in = rs_ff;
      big_in = big_ff;  m_in = m_ff;  bm_in = bm_ff;  bs_in = bs_ff;
      t_in = t_ff;  dvs_in = dvs_ff;  found_in = found_ff;
      parity_in = parity_ff;  sing_in = sing_ff;
      piv_in = piv_ff;  l_in = l_ff;  prod_in = prod_ff;
      rem_in = rem_ff;  dq_in = dq_ff;  dcnt_in = dcnt_ff;  dneg_in = dneg_ff;
      rsp_valid_in = rsp_valid_ff;  rsp_lu_in = rsp_lu_ff;  rsp_piv_in = rsp_piv_ff;
      rsp_par_in = rsp_par_ff;  rsp_sing_in = rsp_sing_ff;  rsp_last_in = rsp_last_ff;
      mem_we = 1'b0;  mem_waddr = '0;  mem_wdata = '0;  mem_raddr = '0;
      mul_a = '0;  mul_b = '0;
      big_val = (m_val > big_ff) ? m_val : big_ff;
      pv_adv = 1'b0;  take = 1'b0;

      case (state_ff)
         lupp_pkg::S_LOAD: begin
            if (req_valid) begin
               mem_we    = 1'b1;
               mem_waddr = load_cnt_ff;
               mem_wdata = req_element_value;
               if (load_cnt_ff == CNT_LAST) begin
                  load_cnt_in = '0;
                  r_in = '0;  c_in = '0;  big_in = '0;
                  parity_in = 1'b0;  sing_in = 1'b0;
                  for (int n = 0; n < DIM; n++) pidx_in[n] = '0;
                  state_in = lupp_pkg::S_SC_RD;
               end else begin
                  load_cnt_in = load_cnt_ff + AW'(1);
               end
            end
         end
         lupp_pkg::S_SC_RD: begin
            mem_raddr = idx(r_ff, c_ff);
            state_in  = lupp_pkg::S_SC_ACC;
         end
         lupp_pkg::S_SC_ACC: begin
            if (c_ff == LAST) begin
               rs_in[r_ff] = big_val;
               sing_in = sing_ff | (big_val == '0);
               if (r_ff == LAST) begin
                  orow_in = '0;  ocol_in = '0;
                  k_in = '0;  r_in = '0;  best_in = '0;  found_in = 1'b0;
                  state_in = sing_in ? lupp_pkg::S_OUT_RD : lupp_pkg::S_PV_RD;
               end else begin
                  r_in = r_ff + IW'(1);  c_in = '0;  big_in = '0;
                  state_in = lupp_pkg::S_SC_RD;
               end
            end else begin
               c_in = c_ff + IW'(1);  big_in = big_val;
               state_in = lupp_pkg::S_SC_RD;
            end
         end
         lupp_pkg::S_PV_RD: begin
            mem_raddr = idx(r_ff, k_ff);
            state_in  = lupp_pkg::S_PV_CHK;
         end
         lupp_pkg::S_PV_CHK: begin
            if (m_val == '0) begin
               pv_adv = 1'b1;
            end else if (!found_ff) begin
               m_in = m_val;  take = 1'b1;  pv_adv = 1'b1;
            end else begin
               m_in = m_val;
               state_in = lupp_pkg::S_PV_M1;
            end
         end
         lupp_pkg::S_PV_M1: begin
            mul_a = {1'b0, m_ff};  mul_b = {1'b0, bs_ff};
            prod_in  = mul_p[63:0];
            state_in = lupp_pkg::S_PV_M2;
         end
         lupp_pkg::S_PV_M2: begin
            // cross-multiplied ratio compare, strictly larger wins
            mul_a = {1'b0, bm_ff};  mul_b = {1'b0, rs_ff[r_ff]};
            take   = prod_ff > mul_p[63:0];
            pv_adv = 1'b1;
         end
         lupp_pkg::S_SW_RDA: begin
            mem_raddr = idx(best_ff, c_ff);
            state_in  = lupp_pkg::S_SW_RDB;
         end
         lupp_pkg::S_SW_RDB: begin
            t_in      = mem_q_ff;
            mem_raddr = idx(k_ff, c_ff);
            state_in  = lupp_pkg::S_SW_WRB;
         end
         lupp_pkg::S_SW_WRB: begin
            mem_we = 1'b1;  mem_waddr = idx(best_ff, c_ff);  mem_wdata = mem_q_ff;
            state_in = lupp_pkg::S_SW_WRK;
         end
         lupp_pkg::S_SW_WRK: begin
            mem_we = 1'b1;  mem_waddr = idx(k_ff, c_ff);  mem_wdata = t_ff;
            if (c_ff == LAST) begin
               state_in = lupp_pkg::S_SS_A;
            end else begin
               c_in = c_ff + IW'(1);
               state_in = lupp_pkg::S_SW_RDA;
            end
         end
         lupp_pkg::S_SS_A: begin
            t_in     = rs_ff[best_ff];
            state_in = lupp_pkg::S_SS_B;
         end
         lupp_pkg::S_SS_B: begin
            rs_in[best_ff] = rs_ff[k_ff];
            rs_in[k_ff]    = t_ff;
            parity_in      = ~parity_ff;
            state_in       = lupp_pkg::S_PP_RD;
         end
         lupp_pkg::S_PP_RD: begin
            mem_raddr = idx(k_ff, k_ff);
            state_in  = lupp_pkg::S_PP_CHK;
         end
         lupp_pkg::S_PP_CHK: begin
            // zero pivot becomes the smallest positive step
            if (mem_q_ff == '0) begin
               mem_we = 1'b1;  mem_waddr = idx(k_ff, k_ff);  mem_wdata = DW'(1);
               piv_in = DW'(1);
            end else begin
               piv_in = mem_q_ff;
            end
            if (k_ff == LAST) begin
               orow_in = '0;  ocol_in = '0;
               state_in = lupp_pkg::S_OUT_RD;
            end else begin
               i_in = k_ff + IW'(1);
               state_in = lupp_pkg::S_EL_RD;
            end
         end
         lupp_pkg::S_EL_RD: begin
            mem_raddr = idx(i_ff, k_ff);
            state_in  = lupp_pkg::S_EL_INI;
         end
         lupp_pkg::S_EL_INI: begin
            dq_in   = {m_val, {lupp_pkg::FRAC_W{1'b0}}};
            rem_in  = '0;
            dneg_in = mem_q_ff[DW-1] ^ piv_ff[DW-1];
            dvs_in  = mag(piv_ff);
            dcnt_in = '0;
            state_in = lupp_pkg::S_EL_DIV;
         end
         lupp_pkg::S_EL_DIV: begin
            rem_in  = div_ge ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;
            dq_in   = {dq_ff[QW-2:0], div_ge};
            dcnt_in = dcnt_ff + CW'(1);
            if (dcnt_ff == DIV_LAST) state_in = lupp_pkg::S_EL_WR;
         end
         lupp_pkg::S_EL_WR: begin
            l_in   = l_val;
            mem_we = 1'b1;  mem_waddr = idx(i_ff, k_ff);  mem_wdata = l_val;
            j_in   = k_ff + IW'(1);
            state_in = lupp_pkg::S_RD_KJ;
         end
         lupp_pkg::S_RD_KJ: begin
            mem_raddr = idx(k_ff, j_ff);
            state_in  = lupp_pkg::S_MUL;
         end
         lupp_pkg::S_MUL: begin
            mul_a = {l_ff[DW-1], l_ff};  mul_b = {mem_q_ff[DW-1], mem_q_ff};
            prod_in   = mul_p[63:0];
            mem_raddr = idx(i_ff, j_ff);
            state_in  = lupp_pkg::S_SUB;
         end
         lupp_pkg::S_SUB: begin
            mem_we = 1'b1;  mem_waddr = idx(i_ff, j_ff);  mem_wdata = sub_val;
            if (j_ff == LAST) begin
               if (i_ff == LAST) begin
                  k_in = k_ff + IW'(1);  r_in = k_ff + IW'(1);  best_in = k_ff + IW'(1);
                  found_in = 1'b0;
                  state_in = lupp_pkg::S_PV_RD;
               end else begin
                  i_in = i_ff + IW'(1);
                  state_in = lupp_pkg::S_EL_RD;
               end
            end else begin
               j_in = j_ff + IW'(1);
               state_in = lupp_pkg::S_RD_KJ;
            end
         end
         lupp_pkg::S_OUT_RD: begin
            mem_raddr = idx(orow_ff, ocol_ff);
            state_in  = lupp_pkg::S_OUT_SH;
         end
         lupp_pkg::S_OUT_SH: begin
            mem_raddr = idx(orow_ff, ocol_ff);
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_lu_in    = mem_q_ff;
               rsp_piv_in   = lupp_pkg::PIVOT_W'(pidx_ff[orow_ff]);
               rsp_par_in   = parity_ff;
               rsp_sing_in  = sing_ff;
               rsp_last_in  = (orow_ff == LAST) && (ocol_ff == LAST);
            end else if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (ocol_ff == LAST) begin
                  ocol_in = '0;
                  if (orow_ff == LAST) begin
                     state_in = lupp_pkg::S_LOAD;
                  end else begin
                     orow_in  = orow_ff + IW'(1);
                     state_in = lupp_pkg::S_OUT_RD;
                  end
               end else begin
                  ocol_in  = ocol_ff + IW'(1);
                  state_in = lupp_pkg::S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = lupp_pkg::S_LOAD;
         end
      endcase

      if (take) begin
         found_in = 1'b1;
         best_in  = r_ff;
         bm_in    = m_in;
         bs_in    = rs_ff[r_ff];
      end
      if (pv_adv) begin
         if (r_ff == LAST) begin
            pidx_in[k_ff] = best_in;
            c_in = '0;
            state_in = (best_in != k_ff) ? lupp_pkg::S_SW_RDA : lupp_pkg::S_PP_RD;
         end else begin
            r_in = r_ff + IW'(1);
            state_in = lupp_pkg::S_PV_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      mem_q_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lupp_pkg::S_LOAD;
         load_cnt_ff  <= '0;
         parity_ff    <= 1'b0;
         sing_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int n = 0; n < DIM; n++) pidx_ff[n] <= '0;
      end else begin
         state_ff     <= state_in;
         load_cnt_ff  <= load_cnt_in;
         parity_ff    <= parity_in;
         sing_ff      <= sing_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         pidx_ff      <= pidx_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;  c_ff <= c_in;  k_ff <= k_in;  i_ff <= i_in;  j_ff <= j_in;
      best_ff <= best_in;  orow_ff <= orow_in;  ocol_ff <= ocol_in;
      rs_ff <= rs_in;
      big_ff <= big_in;  m_ff <= m_in;  bm_ff <= bm_in;  bs_ff <= bs_in;
      t_ff <= t_in;  dvs_ff <= dvs_in;
      piv_ff <= piv_in;  l_ff <= l_in;  prod_ff <= prod_in;
      rem_ff <= rem_in;  dq_ff <= dq_in;  dcnt_ff <= dcnt_in;  dneg_ff <= dneg_in;
      rsp_lu_ff <= rsp_lu_in;  rsp_piv_ff <= rsp_piv_in;  rsp_par_ff <= rsp_par_in;
      rsp_sing_ff <= rsp_sing_in;  rsp_last_ff <= rsp_last_in;
   end

   assign req_stall           = (state_ff != lupp_pkg::S_LOAD);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_lu_value        = rsp_lu_ff;
   assign rsp_pivot_row       = rsp_piv_ff;
   assign rsp_parity_negative = rsp_par_ff;
   assign rsp_singular        = rsp_sing_ff;
   assign rsp_last_result     = rsp_last_ff;

`ifndef ASSERT_OFF
   a_rsp_only_in_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == lupp_pkg::S_OUT_SH)
      else $error("result valid outside output phase");

   a_last_returns_to_load: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_result |=> state_ff == lupp_pkg::S_LOAD)
      else $error("final result transaction did not reopen loading");

   a_singular_no_swaps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> !rsp_parity_negative && rsp_pivot_row == '0)
      else $error("singular matrix reported swaps");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while results pending");
`endif

endmodule
